// ===== hw/rtl/tes_pkg.sv =====
// Shared constants, types and helper functions for the triangle element stiffness block.
// Used by every module in hw/rtl; depends on nothing else.
package tes_pkg;

  // Field and datapath widths.
  localparam int COORD_W = 32;
  localparam int DIFF_W = 33;
  localparam int AREA_W = 67;
  localparam int DEN_W = 68;
  localparam int NODE_W = 16;
  localparam int DOF_W = 17;
  localparam int VAL_W = 64;
  localparam int ACC_W = 131;
  localparam int CFG_W = 32;

  // Lane organization and entry counting.
  localparam int NUM_LANES = 4;
  localparam int LANE_IDX_W = $clog2(NUM_LANES);
  localparam int CNT_W = $clog2(NUM_LANES + 1);
  localparam int NUM_ENTRIES = 36;
  localparam int PER_ROW = 12;
  localparam int NUM_GROUPS = NUM_ENTRIES / NUM_LANES;
  localparam int GROUP_W = $clog2(NUM_GROUPS);
  localparam int ENTRY_W = $clog2(NUM_ENTRIES);
  localparam int NUM_TERMS = 4;
  localparam int NUM_PARTS = 4;
  localparam int PART_W = 16;
  localparam int QUO_W = 64;
  localparam int STEP_W = $clog2(QUO_W);

  // Configuration register indexes.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_D11 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_D12 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_D13 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_D22 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_D23 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_D33 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_THICK = 3'd6;
  localparam logic [CFG_W-1:0] THICK_RESET = 32'h0001_0000;

  // Saturation limits of the Q32.32 result.
  localparam logic [VAL_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [CFG_W-1:0] d11;
    logic signed [CFG_W-1:0] d12;
    logic signed [CFG_W-1:0] d13;
    logic signed [CFG_W-1:0] d22;
    logic signed [CFG_W-1:0] d23;
    logic signed [CFG_W-1:0] d33;
  } dmat_t;

  // Geometry of one element, ready for the lanes.
  typedef struct packed {
    logic [2:0][DIFF_W-1:0] b;
    logic [2:0][DIFF_W-1:0] c;
    logic [DEN_W-1:0] den;
    logic degen;
    logic [2:0][NODE_W-1:0] node;
  } elem_t;

  // Operands of one matrix entry handed to a lane.
  typedef struct packed {
    logic signed [DIFF_W-1:0] u_b;
    logic signed [DIFF_W-1:0] u_c;
    logic signed [DIFF_W-1:0] v_b;
    logic signed [DIFF_W-1:0] v_c;
    logic r;
    logic s;
  } lane_op_t;

  // Position tag that travels with a lane result.
  typedef struct packed {
    logic [DOF_W-1:0] row_dof;
    logic [DOF_W-1:0] col_dof;
    logic last;
  } lane_tag_t;

  typedef struct packed {
    logic [1:0] i;
    logic [1:0] j;
    logic r;
    logic s;
  } epos_t;

  // Split an entry number into node pair and direction pair, row-major order.
  function automatic epos_t entry_pos(logic [ENTRY_W-1:0] n);
    epos_t e;
    logic [ENTRY_W-1:0] rem;
    if (n >= ENTRY_W'(2 * PER_ROW)) begin
      e.i = 2'd2;
      rem = n - ENTRY_W'(2 * PER_ROW);
    end else if (n >= ENTRY_W'(PER_ROW)) begin
      e.i = 2'd1;
      rem = n - ENTRY_W'(PER_ROW);
    end else begin
      e.i = 2'd0;
      rem = n;
    end
    e.j = rem[3:2];
    e.r = rem[1];
    e.s = rem[0];
    return e;
  endfunction

  // Entry of the symmetric elasticity matrix.
  function automatic logic signed [CFG_W-1:0] d_entry(dmat_t d, logic [1:0] p, logic [1:0] q);
    logic signed [CFG_W-1:0] v;
    unique case ({p, q})
      4'b0000: v = d.d11;
      4'b0001, 4'b0100: v = d.d12;
      4'b0010, 4'b1000: v = d.d13;
      4'b0101: v = d.d22;
      4'b0110, 4'b1001: v = d.d23;
      4'b1010: v = d.d33;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/tes_front.sv =====
// Front end: takes one triangle word, forms the b and c terms and the doubled area.
// Depends on tes_pkg; feeds the element register read by the lane sequencer.
module tes_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            ax,
  input  logic signed [31:0]            ay,
  input  logic signed [31:0]            bx,
  input  logic signed [31:0]            by_coord,
  input  logic signed [31:0]            cx,
  input  logic signed [31:0]            cy,
  input  logic [15:0]                   node_a,
  input  logic [15:0]                   node_b,
  input  logic [15:0]                   node_c,
  output logic                          elem_valid,
  output tes_pkg::elem_t                elem,
  input  logic                          elem_take
);

  typedef enum logic [1:0] {F_IDLE, F_AREA, F_HOLD} fstate_t;

  fstate_t state;
  logic signed [tes_pkg::COORD_W-1:0] xr [3];
  logic signed [tes_pkg::DIFF_W-1:0] br [3];
  logic signed [tes_pkg::DIFF_W-1:0] cr [3];
  logic [2:0][tes_pkg::NODE_W-1:0] nodes;
  logic signed [tes_pkg::AREA_W-1:0] area;
  logic [1:0] k;

  logic signed [64:0] prod;
  logic [tes_pkg::AREA_W-1:0] area_abs;
  logic load_elem;

  // One product of the shoelace sum per cycle.
  assign prod = xr[k] * br[k];
  assign area_abs = area[tes_pkg::AREA_W-1] ? (~area + 1'b1) : area;
  assign in_ready = (state == F_IDLE);
  assign load_elem = (state == F_HOLD) && (!elem_valid || elem_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      elem_valid <= 1'b0;
      k <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            xr[0] <= ax;
            xr[1] <= bx;
            xr[2] <= cx;
            br[0] <= tes_pkg::DIFF_W'(by_coord) - tes_pkg::DIFF_W'(cy);
            br[1] <= tes_pkg::DIFF_W'(cy) - tes_pkg::DIFF_W'(ay);
            br[2] <= tes_pkg::DIFF_W'(ay) - tes_pkg::DIFF_W'(by_coord);
            cr[0] <= tes_pkg::DIFF_W'(cx) - tes_pkg::DIFF_W'(bx);
            cr[1] <= tes_pkg::DIFF_W'(ax) - tes_pkg::DIFF_W'(cx);
            cr[2] <= tes_pkg::DIFF_W'(bx) - tes_pkg::DIFF_W'(ax);
            nodes <= {node_c, node_b, node_a};
            area <= '0;
            k <= '0;
            state <= F_AREA;
          end
        end
        F_AREA: begin
          area <= area + tes_pkg::AREA_W'(prod);
          if (k == 2'd2) begin
            state <= F_HOLD;
          end else begin
            k <= k + 2'd1;
          end
        end
        F_HOLD: begin
          if (load_elem) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase

      // The element register is refilled as soon as the sequencer lets go of it.
      if (load_elem) begin
        elem_valid <= 1'b1;
      end else if (elem_take) begin
        elem_valid <= 1'b0;
      end
    end
  end

  // Element payload, loaded without reset.
  always_ff @(posedge clk) begin
    if (load_elem) begin
      for (int i = 0; i < 3; i++) begin
        elem.b[i] <= br[i];
        elem.c[i] <= cr[i];
      end
      elem.node <= nodes;
      elem.degen <= (area == '0);
      elem.den <= {area_abs, 1'b0};
    end
  end

endmodule

// ===== hw/rtl/tes_lane.sv =====
// One lane: computes a single stiffness entry from its operands.
// Depends on tes_pkg. Serial multiply-accumulate, then a restoring divide by 2*|2A|.
module tes_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  tes_pkg::lane_op_t             op,
  input  tes_pkg::dmat_t                dm,
  input  logic [tes_pkg::CFG_W-1:0]     thick,
  input  logic [tes_pkg::DEN_W-1:0]     den,
  output logic                          done,
  output logic [tes_pkg::VAL_W-1:0]     value
);

  typedef enum logic [2:0] {L_IDLE, L_MUL, L_PART, L_SETUP, L_DIV, L_ROUND, L_DONE} lstate_t;

  lstate_t state;
  logic [1:0] term;
  logic [1:0] part;
  logic [63:0] a_mag;
  logic [63:0] b_mag;
  logic tsign;
  logic [tes_pkg::ACC_W-1:0] acc;
  logic neg;
  logic ovf;
  logic [tes_pkg::DEN_W-1:0] rem;
  logic [tes_pkg::QUO_W-1:0] low;
  logic [tes_pkg::QUO_W-1:0] quo;
  logic [tes_pkg::STEP_W-1:0] step;

  logic signed [tes_pkg::DIFF_W-1:0] u_val, v_val;
  logic [1:0] u_idx, v_idx;
  logic signed [tes_pkg::CFG_W-1:0] d_val;
  logic [tes_pkg::DIFF_W-1:0] u_abs, v_abs;
  logic [tes_pkg::CFG_W-1:0] d_abs;
  logic [64:0] prod_a, prod_b;
  logic [tes_pkg::PART_W-1:0] chunk;
  logic [79:0] pp;
  logic [tes_pkg::ACC_W-1:0] shifted;
  logic [tes_pkg::ACC_W-1:0] mag;
  logic [tes_pkg::DEN_W:0] rem2;
  logic [tes_pkg::DEN_W:0] rem_dbl;
  logic rnd;
  logic [tes_pkg::QUO_W:0] qr;
  logic big;

  // Pick the two nonzero components of u and v for the current term.
  always_comb begin
    if (!term[1]) begin
      u_val = op.r ? op.u_c : op.u_b;
      u_idx = op.r ? 2'd1 : 2'd0;
    end else begin
      u_val = op.r ? op.u_b : op.u_c;
      u_idx = 2'd2;
    end
    if (!term[0]) begin
      v_val = op.s ? op.v_c : op.v_b;
      v_idx = op.s ? 2'd1 : 2'd0;
    end else begin
      v_val = op.s ? op.v_b : op.v_c;
      v_idx = 2'd2;
    end
  end

  assign d_val = tes_pkg::d_entry(dm, u_idx, v_idx);
  assign u_abs = u_val[tes_pkg::DIFF_W-1] ? (~u_val + 1'b1) : u_val;
  assign v_abs = v_val[tes_pkg::DIFF_W-1] ? (~v_val + 1'b1) : v_val;
  assign d_abs = d_val[tes_pkg::CFG_W-1] ? (~d_val + 1'b1) : d_val;
  assign prod_a = 65'(u_abs) * 65'(d_abs);
  assign prod_b = 65'(v_abs) * 65'(thick);

  // One 16-bit slice of the second factor per cycle.
  assign chunk = b_mag[part*tes_pkg::PART_W +: tes_pkg::PART_W];
  assign pp = 80'(a_mag) * 80'(chunk);
  assign shifted = tes_pkg::ACC_W'(pp) << (part * tes_pkg::PART_W);

  // Division steps.
  assign mag = acc[tes_pkg::ACC_W-1] ? (~acc + 1'b1) : acc;
  assign rem2 = {rem, low[tes_pkg::QUO_W-1]};
  assign rem_dbl = {rem, 1'b0};
  assign rnd = (rem_dbl >= {1'b0, den});
  assign qr = {1'b0, quo} + (tes_pkg::QUO_W + 1)'(rnd);
  assign big = ovf || qr[tes_pkg::QUO_W] || qr[tes_pkg::QUO_W-1];

  assign done = (state == L_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      term <= '0;
      part <= '0;
      step <= '0;
    end else begin
      unique case (state)
        L_IDLE, L_DONE: begin
          if (start) begin
            term <= '0;
            acc <= '0;
            state <= L_MUL;
          end
        end
        L_MUL: begin
          a_mag <= prod_a[63:0];
          b_mag <= prod_b[63:0];
          tsign <= u_val[tes_pkg::DIFF_W-1] ^ v_val[tes_pkg::DIFF_W-1]
                   ^ d_val[tes_pkg::CFG_W-1];
          part <= '0;
          state <= L_PART;
        end
        L_PART: begin
          acc <= tsign ? (acc - shifted) : (acc + shifted);
          part <= part + 2'd1;
          if (part == 2'(tes_pkg::NUM_PARTS - 1)) begin
            if (term == 2'(tes_pkg::NUM_TERMS - 1)) begin
              state <= L_SETUP;
            end else begin
              term <= term + 2'd1;
              state <= L_MUL;
            end
          end
        end
        L_SETUP: begin
          neg <= acc[tes_pkg::ACC_W-1];
          ovf <= ({1'b0, mag} >= {den, {tes_pkg::QUO_W{1'b0}}});
          rem <= tes_pkg::DEN_W'(mag[tes_pkg::ACC_W-1:tes_pkg::QUO_W]);
          low <= mag[tes_pkg::QUO_W-1:0];
          quo <= '0;
          step <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          if (rem2 >= {1'b0, den}) begin
            rem <= tes_pkg::DEN_W'(rem2 - {1'b0, den});
            quo <= {quo[tes_pkg::QUO_W-2:0], 1'b1};
          end else begin
            rem <= rem2[tes_pkg::DEN_W-1:0];
            quo <= {quo[tes_pkg::QUO_W-2:0], 1'b0};
          end
          low <= {low[tes_pkg::QUO_W-2:0], 1'b0};
          step <= step + 1'b1;
          if (step == tes_pkg::STEP_W'(tes_pkg::QUO_W - 1)) begin
            state <= L_ROUND;
          end
        end
        L_ROUND: begin
          if (neg) begin
            value <= big ? tes_pkg::VAL_MIN : (~qr[tes_pkg::VAL_W-1:0] + 1'b1);
          end else begin
            value <= big ? tes_pkg::VAL_MAX : qr[tes_pkg::VAL_W-1:0];
          end
          state <= L_DONE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tes_merge.sv =====
// Merging stage: buffers a lane group, sends one word a cycle while out_ready allows.
// Depends on tes_pkg; drives the output channel registers.
module tes_merge (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        load,
  output logic                                        can_load,
  input  logic [tes_pkg::NUM_LANES-1:0][tes_pkg::VAL_W-1:0] vals,
  input  tes_pkg::lane_tag_t [tes_pkg::NUM_LANES-1:0] tags,
  input  logic                                        degen,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [16:0]                                 row_dof,
  output logic [16:0]                                 col_dof,
  output logic signed [63:0]                          stiffness,
  output logic                                        degenerate,
  output logic                                        last
);

  logic [tes_pkg::VAL_W-1:0] hold_val [tes_pkg::NUM_LANES];
  tes_pkg::lane_tag_t hold_tag [tes_pkg::NUM_LANES];
  logic hold_degen;
  logic [tes_pkg::CNT_W-1:0] cnt;
  logic [tes_pkg::LANE_IDX_W-1:0] rd;
  logic pop;

  assign can_load = (cnt == '0);
  assign pop = (cnt != '0) && (!out_valid || out_ready);

  // Group buffer and output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cnt <= tes_pkg::CNT_W'(tes_pkg::NUM_LANES);
        rd <= '0;
      end else if (pop) begin
        cnt <= cnt - 1'b1;
        rd <= rd + 1'b1;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload; a degenerate element reports zero values.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int l = 0; l < tes_pkg::NUM_LANES; l++) begin
        hold_val[l] <= vals[l];
        hold_tag[l] <= tags[l];
      end
      hold_degen <= degen;
    end
    if (pop) begin
      row_dof <= hold_tag[rd].row_dof;
      col_dof <= hold_tag[rd].col_dof;
      last <= hold_tag[rd].last;
      degenerate <= hold_degen;
      stiffness <= hold_degen ? '0 : hold_val[rd];
    end
  end

endmodule

// ===== hw/rtl/triangle_element_stiffness.sv =====
// Top level of the triangle element stiffness block: configuration registers,
// group sequencer, and the front, lane and merge modules. Depends on tes_pkg.
//
// Usage: one input word per triangle (three node coordinates in Q16.16 and
// three node numbers) on in_valid/in_ready. For each triangle the block sends
// 36 output words (row_dof, col_dof, Q32.32 stiffness, degenerate, last) on
// out_valid/out_ready, row-major over node pairs, last marking the 36th word.
// Configuration is to be written through cfg_wen/cfg_idx/cfg_wdata while idle;
// the block does not enforce this. Four lanes work on four entries at once,
// each with a serial multiply-accumulate and a 64-step serial divider, so a
// triangle is worked in nine groups of four entries.
// The front end accepts and prepares the next triangle while the lanes work.
// Reset clears all control state and loads the D entries with 0 and the
// thickness with 1.0. When the receiver stalls, the four-word group buffer
// fills and the lanes wait with their results, then the front end fills up
// and in_ready drops; no word is lost.
module triangle_element_stiffness (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [2:0]            cfg_idx,
  input  logic [31:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    ax,
  input  logic signed [31:0]    ay,
  input  logic signed [31:0]    bx,
  input  logic signed [31:0]    by_coord,
  input  logic signed [31:0]    cx,
  input  logic signed [31:0]    cy,
  input  logic [15:0]           node_a,
  input  logic [15:0]           node_b,
  input  logic [15:0]           node_c,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [16:0]           row_dof,
  output logic [16:0]           col_dof,
  output logic signed [63:0]    stiffness,
  output logic                  degenerate,
  output logic                  last
);

  typedef enum logic [1:0] {S_IDLE, S_START, S_RUN} sstate_t;

  tes_pkg::dmat_t dm;
  logic [tes_pkg::CFG_W-1:0] thick;
  sstate_t state;
  logic [tes_pkg::GROUP_W-1:0] grp;

  logic elem_valid;
  tes_pkg::elem_t elem;
  logic elem_take;
  logic lane_start;
  logic [tes_pkg::NUM_LANES-1:0] lane_done;
  logic [tes_pkg::NUM_LANES-1:0][tes_pkg::VAL_W-1:0] lane_val;
  tes_pkg::lane_tag_t [tes_pkg::NUM_LANES-1:0] lane_tag;
  logic merge_load;
  logic merge_ready;
  logic all_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dm <= '0;
      thick <= tes_pkg::THICK_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        tes_pkg::REG_D11: dm.d11 <= cfg_wdata;
        tes_pkg::REG_D12: dm.d12 <= cfg_wdata;
        tes_pkg::REG_D13: dm.d13 <= cfg_wdata;
        tes_pkg::REG_D22: dm.d22 <= cfg_wdata;
        tes_pkg::REG_D23: dm.d23 <= cfg_wdata;
        tes_pkg::REG_D33: dm.d33 <= cfg_wdata;
        tes_pkg::REG_THICK: thick <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tes_front u_front (
    .clk, .rst, .in_valid, .in_ready,
    .ax, .ay, .bx, .by_coord, .cx, .cy,
    .node_a, .node_b, .node_c,
    .elem_valid, .elem, .elem_take
  );

  // Lanes, each on its own entry of the current group.
  for (genvar l = 0; l < tes_pkg::NUM_LANES; l++) begin : g_lane
    logic [tes_pkg::ENTRY_W-1:0] n;
    tes_pkg::epos_t e;
    tes_pkg::lane_op_t op;

    assign n = tes_pkg::ENTRY_W'(int'(grp) * tes_pkg::NUM_LANES + l);
    assign e = tes_pkg::entry_pos(n);
    assign op.u_b = elem.b[e.i];
    assign op.u_c = elem.c[e.i];
    assign op.v_b = elem.b[e.j];
    assign op.v_c = elem.c[e.j];
    assign op.r = e.r;
    assign op.s = e.s;
    assign lane_tag[l].row_dof = {elem.node[e.i], e.r};
    assign lane_tag[l].col_dof = {elem.node[e.j], e.s};
    assign lane_tag[l].last = (n == tes_pkg::ENTRY_W'(tes_pkg::NUM_ENTRIES - 1));

    tes_lane u_lane (
      .clk, .rst,
      .start (lane_start),
      .op,
      .dm,
      .thick,
      .den   (elem.den),
      .done  (lane_done[l]),
      .value (lane_val[l])
    );
  end

  assign all_done = &lane_done;
  assign lane_start = (state == S_START);
  assign merge_load = (state == S_RUN) && all_done && merge_ready;
  assign elem_take = merge_load && (grp == tes_pkg::GROUP_W'(tes_pkg::NUM_GROUPS - 1));

  // Group sequencer: four entries at a time until all 36 are out.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      grp <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (elem_valid) begin
            grp <= '0;
            state <= S_START;
          end
        end
        S_START: state <= S_RUN;
        S_RUN: begin
          if (merge_load) begin
            if (elem_take) begin
              state <= S_IDLE;
            end else begin
              grp <= grp + 1'b1;
              state <= S_START;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  tes_merge u_merge (
    .clk, .rst,
    .load      (merge_load),
    .can_load  (merge_ready),
    .vals      (lane_val),
    .tags      (lane_tag),
    .degen     (elem.degen),
    .out_valid, .out_ready,
    .row_dof, .col_dof, .stiffness, .degenerate, .last
  );

  // The lanes run in lockstep, so their done flags always agree.
  assert property (@(posedge clk) disable iff (rst)
    (&lane_done) || !(|lane_done))
    else $error("lanes out of step");

  // A started group leaves every lane busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_START) |=> !(|lane_done))
    else $error("lane done right after start");

  // Degenerate elements report zero stiffness.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (stiffness == '0))
    else $error("nonzero value on degenerate element");

endmodule
